// ----- hdl/ush_pkg.sv -----
// Shared types, constants and helper functions for the username/serial check block.
// No dependencies; every other file in hdl/ refers to it by scoped names.
package ush_pkg;

	// Accumulator seeds and mixing constants
	localparam logic [31:0] FIRST_INIT    = 32'd5381;
	localparam logic [31:0] SECOND_INIT   = 32'd2166136261;
	localparam logic [31:0] SECOND_MULT   = 32'd16777619;
	localparam logic [31:0] REDUCE_MOD    = 32'd100000000;
	localparam logic [3:0]  SERIAL_DIGITS = 4'd8;

	// Reciprocal of REDUCE_MOD: q ~= (x * RECIP_MULT) >> RECIP_SHIFT, low by at most one
	localparam logic [11:0] RECIP_MULT  = 12'd2748;
	localparam int          RECIP_SHIFT = 38;
	localparam int          RECIP_W     = 32 + 12;
	localparam int          QUOT_W      = RECIP_W - RECIP_SHIFT;

	localparam int VALUE_W = 27;

	// Digit weights, first serial character is the most significant digit
	localparam logic [VALUE_W-1:0] POW10 [8] = '{
		27'd10000000, 27'd1000000, 27'd100000, 27'd10000,
		27'd1000,     27'd100,     27'd10,     27'd1
	};

	// Snapshot of the accumulators plus the serial candidate
	typedef struct packed {
		logic [31:0] first;
		logic [31:0] second;
		logic [63:0] serial_chars;
		logic [3:0]  serial_length;
	} snap_t;

	// Result item, laid out as it travels in the output tdata (lowest bit last)
	typedef struct packed {
		logic [VALUE_W-1:0] expected_value;
		logic               format_ok;
		logic               accepted;
	} result_t;

	// Combine the accumulators and run the 13/7/17 xorshift
	function automatic logic [31:0] mix_state(input logic [31:0] first, input logic [31:0] second);
		logic [31:0] m;
		m = first ^ (second >> 1);
		m = m ^ (m << 13);
		m = m ^ (m >> 7);
		m = m ^ (m << 17);
		return m;
	endfunction

endpackage

// ----- hdl/ush_accum.sv -----
// Input side: the two username accumulators, the position counter and the stage-1
// snapshot register taken on a check transaction. Uses ush_pkg.
module ush_accum (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               mode,
	input  logic [7:0]         name_char,
	input  logic [63:0]        serial_chars,
	input  logic [3:0]         serial_length,
	output ush_pkg::snap_t     snap_s1,
	output logic               snap_valid,
	input  logic               snap_ready
);

	logic [31:0] first_q;
	logic [31:0] second_q;
	logic [7:0]  pos_q;
	logic        valid_s1;
	logic        accept;

	logic [8:0]  first_term;
	logic [7:0]  pos_x17;
	logic [8:0]  second_term;
	logic [31:0] second_mixed;
	logic [31:0] first_d;
	logic [31:0] second_d;

	// Stage 1 frees up when empty or when stage 2 takes it
	assign in_ready   = !valid_s1 || snap_ready;
	assign accept     = in_valid && in_ready;
	assign snap_valid = valid_s1;

	// Per-byte update: first*33 ^ (c+p), (second ^ (c + 17p mod 256)) * FNV prime
	always_comb begin
		first_term   = {1'b0, name_char} + {1'b0, pos_q};
		pos_x17      = pos_q + {pos_q[3:0], 4'd0};
		second_term  = {1'b0, name_char} + {1'b0, pos_x17};
		first_d      = ({first_q[26:0], 5'd0} + first_q) ^ {23'd0, first_term};
		second_mixed = second_q ^ {23'd0, second_term};
		second_d     = second_mixed * ush_pkg::SECOND_MULT;
	end

	// Accumulators: fold on a name byte, back to seeds after a check
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q  <= ush_pkg::FIRST_INIT;
			second_q <= ush_pkg::SECOND_INIT;
			pos_q    <= 8'd0;
		end else if (accept) begin
			if (mode) begin
				first_q  <= ush_pkg::FIRST_INIT;
				second_q <= ush_pkg::SECOND_INIT;
				pos_q    <= 8'd0;
			end else begin
				first_q  <= first_d;
				second_q <= second_d;
				pos_q    <= pos_q + 8'd1;
			end
		end
	end

	// Stage-1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept && mode) begin
			valid_s1 <= 1'b1;
		end else if (snap_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	// Stage-1 payload: state as it stood before this check
	always_ff @(posedge clk) begin
		if (accept && mode) begin
			snap_s1.first         <= first_q;
			snap_s1.second        <= second_q;
			snap_s1.serial_chars  <= serial_chars;
			snap_s1.serial_length <= serial_length;
		end
	end

endmodule

// ----- hdl/ush_check.sv -----
// Check pipeline: xorshift and serial decode (stage 2), reciprocal quotient (stage 3),
// remainder, correction and compare feeding the result register. Uses ush_pkg.
module ush_check (
	input  logic               clk,
	input  logic               arst_n,
	input  ush_pkg::snap_t     snap_s1,
	input  logic               snap_valid,
	output logic               snap_ready,
	output ush_pkg::result_t   result,
	output logic               result_valid,
	input  logic               result_ready
);

	logic                          valid_s2;
	logic                          valid_s3;
	logic                          ready_s2;
	logic                          ready_s3;

	logic [31:0]                   mix_s2;
	logic                          fmt_s2;
	logic [ush_pkg::VALUE_W-1:0]   value_s2;

	logic [31:0]                   mix_s3;
	logic                          fmt_s3;
	logic [ush_pkg::VALUE_W-1:0]   value_s3;
	logic [ush_pkg::QUOT_W-1:0]    quot_s3;

	logic [31:0]                   mix_d;
	logic                          fmt_d;
	logic [ush_pkg::VALUE_W-1:0]   value_d;
	logic [7:0]                    ch;
	logic [ush_pkg::RECIP_W-1:0]   recip_prod;
	logic [31:0]                   quot_prod;
	logic [31:0]                   rem_raw;
	logic [31:0]                   rem_fix;

	// Backpressure chain
	assign ready_s3     = !valid_s3 || result_ready;
	assign ready_s2     = !valid_s2 || ready_s3;
	assign snap_ready   = ready_s2;
	assign result_valid = valid_s3;

	// Stage 2 logic: mix the state, validate and convert the eight digits
	always_comb begin
		mix_d   = ush_pkg::mix_state(snap_s1.first, snap_s1.second);
		fmt_d   = (snap_s1.serial_length == ush_pkg::SERIAL_DIGITS);
		value_d = '0;
		ch      = '0;
		for (int k = 0; k < 8; k++) begin
			ch = snap_s1.serial_chars[8*k +: 8];
			if (!(ch inside {[8'h30:8'h39]})) begin
				fmt_d = 1'b0;
			end
			value_d = value_d + ush_pkg::VALUE_W'(ch[3:0]) * ush_pkg::POW10[k];
		end
	end

	// Stage 3 logic: quotient estimate by reciprocal multiply
	assign recip_prod = ush_pkg::RECIP_W'(mix_s2) * ush_pkg::RECIP_W'(ush_pkg::RECIP_MULT);

	// Output logic: remainder with one correction step, then compare
	always_comb begin
		quot_prod = 32'(quot_s3) * ush_pkg::REDUCE_MOD;
		rem_raw   = mix_s3 - quot_prod;
		rem_fix   = (rem_raw >= ush_pkg::REDUCE_MOD) ? rem_raw - ush_pkg::REDUCE_MOD : rem_raw;
		result.expected_value = rem_fix[ush_pkg::VALUE_W-1:0];
		result.format_ok      = fmt_s3;
		result.accepted       = fmt_s3 && (value_s3 == rem_fix[ush_pkg::VALUE_W-1:0]);
	end

	// Stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (ready_s2) begin
				valid_s2 <= snap_valid;
			end
			if (ready_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	// Stage payloads
	always_ff @(posedge clk) begin
		if (ready_s2 && snap_valid) begin
			mix_s2   <= mix_d;
			fmt_s2   <= fmt_d;
			value_s2 <= value_d;
		end
		if (ready_s3 && valid_s2) begin
			mix_s3   <= mix_s2;
			fmt_s3   <= fmt_s2;
			value_s3 <= value_s2;
			quot_s3  <= recip_prod[ush_pkg::RECIP_W-1:ush_pkg::RECIP_SHIFT];
		end
	end

endmodule

// ----- hdl/username_serial_hash_check.sv -----
// Top level of the username/serial check block: stream ports and result register.
// Depends on ush_pkg, ush_accum and ush_check.
//
// Username bytes arrive as mode 0 transactions (s_tuser = 0), one per cycle while
// s_tready is high, and fold into two 32-bit accumulators with no result. A mode 1
// transaction (s_tuser = 1) carries a serial candidate; it snapshots the accumulators,
// returns them to their seeds, and yields one result transaction: format_ok (length 8
// and all digits), the expected value in 0..99999999, and accepted. The block takes
// one transaction per cycle of either kind while s_tready is high; the bound is the
// per-byte accumulator update, a 32-bit constant multiply inside the accumulator
// feedback loop. A result passes the snapshot, mix/decode, quotient and result
// registers before it shows on m_tvalid, and up to four checks may be in flight;
// s_tready drops only while every stage is full and the result is not taken.
module username_serial_hash_check (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,  // [7:0] name_char, [71:8] serial_chars, [75:72] serial_length
	input  logic        s_tuser,  // [0] mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata   // [0] accepted, [1] format_ok, [28:2] expected_value
);

	ush_pkg::snap_t   snap_s1;
	logic             snap_valid;
	logic             snap_ready;
	ush_pkg::result_t result;
	logic             result_valid;
	logic             result_ready;
	ush_pkg::result_t result_q;
	logic             m_tvalid_q;

	ush_accum u_accum (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_tvalid),
		.in_ready      (s_tready),
		.mode          (s_tuser),
		.name_char     (s_tdata[7:0]),
		.serial_chars  (s_tdata[71:8]),
		.serial_length (s_tdata[75:72]),
		.snap_s1       (snap_s1),
		.snap_valid    (snap_valid),
		.snap_ready    (snap_ready)
	);

	ush_check u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.snap_s1      (snap_s1),
		.snap_valid   (snap_valid),
		.snap_ready   (snap_ready),
		.result       (result),
		.result_valid (result_valid),
		.result_ready (result_ready)
	);

	// Result register
	assign result_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (result_ready) begin
			m_tvalid_q <= result_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (result_ready && result_valid) begin
			result_q <= result;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {3'd0, result_q.expected_value, result_q.format_ok, result_q.accepted};

	// A match is only reported for a well-formed serial
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[0] && !m_tdata[1]))
		else $error("accepted set without format_ok");

	// Reduction always lands below the modulus
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ({3'd0, m_tdata[28:2]} < ush_pkg::REDUCE_MOD))
		else $error("expected_value out of range");

	// Input stalls only when the whole pipe is backed up behind a held result
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (m_tvalid && !m_tready))
		else $error("input stalled without output backpressure");

endmodule
